/* rtl/rft_pkg.sv */
// Package for the fragment reassembly tracker.
// Holds command and status codes, header constants and the beat structs.
// No dependencies.
`timescale 1ns / 1ps

package rft_pkg;

  localparam logic [7:0] HDR_LEN      = 8'd11;
  localparam logic [7:0] ID_MASK      = 8'h7F;
  localparam logic [7:0] FINAL_BIT    = 8'h80;
  localparam logic [7:0] BUDGET_RESET = 8'd5;
  localparam logic [7:0] COUNT_MAX    = 8'hFF;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_VERIFY = 2'd2;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_ALL_MISSING = 3'd1;
  localparam logic [2:0] STAT_RETX_REQ    = 3'd2;
  localparam logic [2:0] STAT_RETX_TMO    = 3'd3;
  localparam logic [2:0] STAT_TOO_SHORT   = 3'd4;
  localparam logic [2:0] STAT_TOO_LARGE   = 3'd5;
  localparam logic [2:0] STAT_ZERO_ID     = 3'd6;
  localparam logic [2:0] STAT_ACCEPTED    = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  frame_len;
    logic [7:0]  frag_id_byte;
    logic [63:0] payload_lo;
    logic [63:0] payload_hi;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  request_id;
    logic [3:0]  out_index;
    logic [4:0]  out_length;
    logic [63:0] out_data_lo;
    logic [63:0] out_data_hi;
    logic        last;
  } out_item_t;

endpackage

/* rtl/rft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rf_fragment_reassembly_tracker_top.sv */
// Top level of the fragment reassembly tracker: command sequencer, flags and counters.
// Depends on rft_pkg and rft_ram.
`timescale 1ns / 1ps

// One item at a time. Clear, add and a verify that ends in a status register their single
// result in the execute state once the output register is free; an unused command gives no
// result. A successful verify walks the fragment RAM through its single read port: the first
// fragment beat is read in the execute state and registered in the emit state, and one more
// follows every cycle while the output is taken. The next item is accepted once the last
// result of the current one is registered; that result may still wait in the output
// register. Payloads beyond frame_len - 11 bytes read back as zero.
module rf_fragment_reassembly_tracker_top import rft_pkg::*; #(
  parameter int unsigned FRAG_SLOTS    = 16,
  parameter int unsigned PAYLOAD_BYTES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned ID_LIMIT = (FRAG_SLOTS < 16) ? FRAG_SLOTS : 16;
  localparam int unsigned NFLAG    = ID_LIMIT - 1;
  localparam int unsigned SLOT_W   = $clog2(ID_LIMIT);
  localparam int unsigned DATA_W   = 8 * PAYLOAD_BYTES;
  localparam int unsigned MEM_W    = 5 + DATA_W;
  localparam logic [7:0]  PAY_MAX  = 8'(PAYLOAD_BYTES);
  localparam logic [6:0]  ID_LIM   = 7'(ID_LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_e;

  state_e           state_q;
  in_item_t         item_q;
  logic [NFLAG-1:0] flags_q;
  logic [3:0]       highest_q;
  logic [6:0]       final_q;
  logic [7:0]       count_q;
  logic [7:0]       budget_q;
  logic [3:0]       k_q;
  out_item_t        out_q;
  logic             out_valid_q;

  logic [6:0]       id;
  logic [6:0]       id_m1;
  logic [7:0]       plen;
  logic             too_short;
  logic             too_large;
  logic             zero_id;
  logic             storable;
  logic [NFLAG-1:0] flag_set;
  logic [127:0]     pay_wide;
  logic [DATA_W-1:0] pay_masked;
  logic [6:0]       miss_id;
  logic             need_req;
  logic [7:0]       req_id;
  logic             granted;
  logic             out_free;
  logic             go;
  logic             emit;
  logic             last_k;
  out_item_t        exec_res;
  logic             exec_has;
  logic             start_emit;
  out_item_t        emit_res;
  logic [127:0]     rd_wide;

  logic              ram_we;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [MEM_W-1:0]  ram_wdata;
  logic [MEM_W-1:0]  ram_rdata;

  assign id        = item_q.frag_id_byte[6:0] & ID_MASK[6:0];
  assign id_m1     = id - 7'd1;
  assign plen      = item_q.frame_len - HDR_LEN;
  assign too_short = item_q.frame_len < HDR_LEN;
  assign too_large = plen > PAY_MAX;
  assign zero_id   = (id == 7'd0);
  assign storable  = (id < ID_LIM);
  assign flag_set  = NFLAG'(1) << id_m1;
  assign pay_wide  = {item_q.payload_hi, item_q.payload_lo};

  always_comb begin
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      pay_masked[8*b +: 8] = (8'(b) < plen) ? pay_wide[8*b +: 8] : 8'd0;
    end
  end

  assign ram_wdata = {plen[4:0], pay_masked};

  always_comb begin
    miss_id = 7'd0;
    if (final_q >= ID_LIM) begin
      miss_id = ID_LIM;
    end
    for (int k = NFLAG; k >= 1; k--) begin
      if ((7'(k) <= final_q) && !flags_q[k-1]) begin
        miss_id = 7'(k);
      end
    end
  end

  assign need_req = (final_q == 7'd0) || (miss_id != 7'd0);
  assign req_id   = (final_q == 7'd0) ? (8'(highest_q) + 8'd1) : {1'b0, miss_id};
  assign granted  = count_q < budget_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign go       = (state_q == ST_EXEC) && out_free;
  assign emit     = (state_q == ST_EMIT) && out_free;
  assign last_k   = ({3'b000, k_q} == final_q);

  always_comb begin
    exec_res   = '0;
    exec_res.last = 1'b1;
    exec_has   = 1'b1;
    start_emit = 1'b0;
    case (item_q.cmd)
      CMD_CLEAR: begin
        exec_res.status = STAT_ACCEPTED;
      end
      CMD_ADD: begin
        if (too_short) begin
          exec_res.status = STAT_TOO_SHORT;
        end else if (too_large) begin
          exec_res.status = STAT_TOO_LARGE;
        end else if (zero_id) begin
          exec_res.status = STAT_ZERO_ID;
        end else begin
          exec_res.status = STAT_ACCEPTED;
        end
      end
      CMD_VERIFY: begin
        if (highest_q == 4'd0) begin
          exec_res.status = STAT_ALL_MISSING;
        end else if (need_req) begin
          if (granted) begin
            exec_res.status     = STAT_RETX_REQ;
            exec_res.request_id = req_id;
          end else begin
            exec_res.status = STAT_RETX_TMO;
          end
        end else begin
          exec_has   = 1'b0;
          start_emit = 1'b1;
        end
      end
      default: begin
        exec_has = 1'b0;
      end
    endcase
  end

  assign rd_wide = 128'(ram_rdata[DATA_W-1:0]);

  always_comb begin
    emit_res             = '0;
    emit_res.status      = STAT_OK;
    emit_res.out_index   = k_q;
    emit_res.out_length  = ram_rdata[MEM_W-1 -: 5];
    emit_res.out_data_lo = rd_wide[63:0];
    emit_res.out_data_hi = rd_wide[127:64];
    emit_res.last        = last_k;
  end

  assign ram_we    = go && (item_q.cmd == CMD_ADD) && !too_short && !too_large &&
                     !zero_id && storable;
  assign ram_re    = (go && start_emit) || (emit && !last_k);
  assign ram_raddr = (state_q == ST_EXEC) ? '0 : k_q[SLOT_W-1:0];

  rft_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ID_LIMIT)
  ) u_frag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (id_m1[SLOT_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      flags_q     <= '0;
      highest_q   <= '0;
      final_q     <= '0;
      count_q     <= '0;
      budget_q    <= BUDGET_RESET;
      k_q         <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        budget_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && !(go && exec_has) && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            if (exec_has) begin
              out_q       <= exec_res;
              out_valid_q <= 1'b1;
            end
            state_q <= ST_IDLE;
            case (item_q.cmd)
              CMD_CLEAR: begin
                flags_q   <= '0;
                highest_q <= '0;
                final_q   <= '0;
                count_q   <= '0;
              end
              CMD_ADD: begin
                if (!too_short && !too_large && !zero_id) begin
                  if (storable) begin
                    flags_q <= flags_q | flag_set;
                    if (id[3:0] > highest_q) begin
                      highest_q <= id[3:0];
                    end
                  end
                  if ((item_q.frag_id_byte & FINAL_BIT) != 8'd0) begin
                    final_q <= id;
                  end
                end
              end
              CMD_VERIFY: begin
                if (start_emit) begin
                  k_q     <= 4'd1;
                  state_q <= ST_EMIT;
                end else if ((highest_q != 4'd0) && (count_q != COUNT_MAX)) begin
                  count_q <= count_q + 8'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q       <= emit_res;
            out_valid_q <= 1'b1;
            if (last_k) begin
              state_q <= ST_IDLE;
            end else begin
              k_q <= k_q + 4'd1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/testbench.sv */
// Self-checking bench for the fragment reassembly tracker: a queue-fed driver,
// an output monitor with an in-bench model of the store, and a stall watchdog.
// Depends on rft_pkg and rf_fragment_reassembly_tracker_top.
`timescale 1ns / 1ps

module testbench;
  import rft_pkg::*;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned PAY_BYTES = 16;
  localparam int unsigned ID_LIMIT  = (SLOTS < 16) ? SLOTS : 16;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_LEN      = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int STORM_BEATS   = 280;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  rf_fragment_reassembly_tracker_top #(
    .FRAG_SLOTS   (SLOTS),
    .PAYLOAD_BYTES(PAY_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  in_item_t  cmd_backlog[$];
  out_item_t response_backlog[$];
  int offered_cnt  = 0;
  int accepted_cnt = 0;
  int fails        = 0;

  logic [7:0]  retry_budget = BUDGET_RESET;
  logic [7:0]  retry_cnt    = '0;
  logic [6:0]  top_id       = '0;
  logic [6:0]  final_id     = '0;
  logic        have_frag [SLOTS] = '{default: 1'b0};
  logic [4:0]  frag_len  [SLOTS] = '{default: '0};
  logic [63:0] frag_lo   [SLOTS];
  logic [63:0] frag_hi   [SLOTS];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic track_command(input in_item_t c);
    out_item_t    r;
    logic [6:0]   id;
    logic [7:0]   plen;
    logic [127:0] keep;
    logic [7:0]   ask;
    r      = '0;
    r.last = 1'b1;
    id     = c.frag_id_byte[6:0];
    ask    = '0;
    case (c.cmd)
      CMD_CLEAR: begin
        have_frag = '{default: 1'b0};
        frag_len  = '{default: '0};
        top_id    = '0;
        final_id  = '0;
        retry_cnt = '0;
        r.status  = STAT_ACCEPTED;
        response_backlog.push_back(r);
      end
      CMD_ADD: begin
        if (c.frame_len < HDR_LEN) begin
          r.status = STAT_TOO_SHORT;
        end else if (c.frame_len - HDR_LEN > PAY_BYTES) begin
          r.status = STAT_TOO_LARGE;
        end else if (id == 7'd0) begin
          r.status = STAT_ZERO_ID;
        end else begin
          plen = c.frame_len - HDR_LEN;
          if (id < ID_LIMIT) begin
            keep = (plen >= 8'd16) ? '1 : ((128'd1 << (8 * plen)) - 128'd1);
            {frag_hi[id - 1], frag_lo[id - 1]} = {c.payload_hi, c.payload_lo} & keep;
            frag_len[id - 1]  = plen[4:0];
            have_frag[id - 1] = 1'b1;
            if (id > top_id) top_id = id;
          end
          if ((c.frag_id_byte & FINAL_BIT) != 8'h00) final_id = id;
          r.status = STAT_ACCEPTED;
        end
        response_backlog.push_back(r);
      end
      CMD_VERIFY: begin
        if (top_id == 7'd0) begin
          r.status = STAT_ALL_MISSING;
          response_backlog.push_back(r);
        end else begin
          if (final_id == 7'd0) begin
            ask = top_id + 8'd1;
          end else begin
            for (int k = 1; k <= final_id; k++) begin
              if (ask == 8'd0 && (k >= ID_LIMIT || !have_frag[k - 1])) ask = 8'(k);
            end
          end
          if (ask != 8'd0) begin
            if (retry_cnt < retry_budget) begin
              r.status     = STAT_RETX_REQ;
              r.request_id = ask;
            end else begin
              r.status = STAT_RETX_TMO;
            end
            if (retry_cnt != COUNT_MAX) retry_cnt++;
            response_backlog.push_back(r);
          end else begin
            for (int k = 1; k <= final_id; k++) begin
              r.status      = STAT_OK;
              r.out_index   = 4'(k);
              r.out_length  = frag_len[k - 1];
              r.out_data_lo = frag_lo[k - 1];
              r.out_data_hi = frag_hi[k - 1];
              r.last        = (k == final_id);
              response_backlog.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t any_item();
    in_item_t it;
    it.cmd          = 2'($urandom);
    it.frame_len    = 8'($urandom);
    it.frag_id_byte = 8'($urandom);
    it.payload_lo   = {$urandom, $urandom};
    it.payload_hi   = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t command(input logic [1:0] cmd);
    in_item_t it;
    it     = any_item();
    it.cmd = cmd;
    return it;
  endfunction

  function automatic in_item_t fragment(input logic [7:0] idb, input int plen);
    in_item_t it;
    it              = command(CMD_ADD);
    it.frag_id_byte = idb;
    it.frame_len    = 8'(plen + HDR_LEN);
    return it;
  endfunction

  // One reassembly try: shuffled adds with drops and noise, verify, resend, maybe verify.
  task automatic queue_session();
    int n;
    int j;
    int tmp;
    int order[$];
    int dropped[$];
    n = ($urandom_range(0, 7) == 0) ? ID_LIMIT - 1 : $urandom_range(1, 5);
    if ($urandom_range(0, 3) != 0) cmd_backlog.push_back(command(CMD_CLEAR));
    for (int i = 1; i <= n; i++) order.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      if ($urandom_range(0, 9) == 0) begin
        dropped.push_back(order[i]);
      end else begin
        cmd_backlog.push_back(fragment(8'(order[i]) | ((order[i] == n) ? FINAL_BIT : 8'h00),
                                       $urandom_range(0, PAY_BYTES)));
      end
      if ($urandom_range(0, 7) == 0) cmd_backlog.push_back(any_item());
    end
    if ($urandom_range(0, 11) == 0) cmd_backlog.push_back(fragment(8'(ID_LIMIT) | FINAL_BIT, 3));
    cmd_backlog.push_back(command(CMD_VERIFY));
    foreach (dropped[i]) begin
      cmd_backlog.push_back(fragment(8'(dropped[i]) | ((dropped[i] == n) ? FINAL_BIT : 8'h00),
                                     $urandom_range(0, PAY_BYTES)));
    end
    if (dropped.size() != 0 || $urandom_range(0, 3) == 0) begin
      cmd_backlog.push_back(command(CMD_VERIFY));
    end
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || offered_cnt != accepted_cnt ||
           response_backlog.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_budget(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= v;
    retry_budget  = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Driver: bursts of beats with random gaps in between.
  int burst_left = 1;
  int gap_left   = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (offered_cnt == accepted_cnt) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= cmd_backlog.pop_front();
        offered_cnt++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: ready bias is redrawn periodically; one long hold once traffic is under way.
  int rx_tick   = 0;
  int rx_bias   = 100;
  int hold_cnt  = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_tick % 64 == 0) rx_bias = 25 * $urandom_range(1, 4);
    if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_cnt++;
      if (hold_cnt == HOLD_LEN) hold_done = 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) < rx_bias);
    end
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_command(in_data_i);
        accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (response_backlog.size() == 0) begin
          $error("unexpected beat: status %0d", out_data_o.status);
          fails++;
        end else begin
          want = response_backlog.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            fails++;
          end
          if (out_data_o.request_id !== want.request_id) begin
            $error("request_id: expected %0d, got %0d", want.request_id, out_data_o.request_id);
            fails++;
          end
          if (out_data_o.out_index !== want.out_index) begin
            $error("out_index: expected %0d, got %0d", want.out_index, out_data_o.out_index);
            fails++;
          end
          if (out_data_o.out_length !== want.out_length) begin
            $error("out_length: expected %0d, got %0d", want.out_length, out_data_o.out_length);
            fails++;
          end
          if (out_data_o.out_data_lo !== want.out_data_lo) begin
            $error("out_data_lo: expected %h, got %h", want.out_data_lo, out_data_o.out_data_lo);
            fails++;
          end
          if (out_data_o.out_data_hi !== want.out_data_hi) begin
            $error("out_data_hi: expected %h, got %h", want.out_data_hi, out_data_o.out_data_hi);
            fails++;
          end
          if (out_data_o.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data_o.last);
            fails++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $error("no beat for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : sequencer
    in_item_t it;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cmd_backlog.push_back(command(CMD_VERIFY));
    it = fragment(8'h01, 0);
    it.frame_len = 8'h00;
    cmd_backlog.push_back(it);
    it.frame_len = HDR_LEN - 8'd1;
    cmd_backlog.push_back(it);
    cmd_backlog.push_back(fragment(8'h01, PAY_BYTES + 1));
    it.frame_len = 8'hFF;
    cmd_backlog.push_back(it);
    cmd_backlog.push_back(fragment(8'h00, 4));
    cmd_backlog.push_back(fragment(FINAL_BIT, 4));
    cmd_backlog.push_back(fragment(8'h01, 0));
    cmd_backlog.push_back(command(CMD_VERIFY));
    it = fragment(8'h02, PAY_BYTES);
    it.payload_lo = '1;
    it.payload_hi = '1;
    cmd_backlog.push_back(it);
    cmd_backlog.push_back(fragment(ID_MASK | FINAL_BIT, 5));
    cmd_backlog.push_back(command(CMD_VERIFY));
    cmd_backlog.push_back(fragment(8'h03, 8));
    cmd_backlog.push_back(fragment(8'h0F, 9));
    cmd_backlog.push_back(fragment(8'h03 | FINAL_BIT, 5));
    cmd_backlog.push_back(command(CMD_VERIFY));
    cmd_backlog.push_back(command(CMD_UNUSED));
    cmd_backlog.push_back(command(CMD_VERIFY));
    cmd_backlog.push_back(fragment(8'(ID_LIMIT) | FINAL_BIT, 7));
    repeat (4) cmd_backlog.push_back(command(CMD_VERIFY));
    cmd_backlog.push_back(command(CMD_CLEAR));
    cmd_backlog.push_back(command(CMD_VERIFY));
    settle();

    set_budget(8'd0);
    repeat (2) queue_session();
    settle();

    // After one clear, drive the retry counter into saturation with a long run of verifies.
    set_budget(COUNT_MAX);
    cmd_backlog.push_back(command(CMD_CLEAR));
    cmd_backlog.push_back(fragment(8'h01, $urandom_range(0, PAY_BYTES)));
    repeat (STORM_BEATS) begin
      if ($urandom_range(0, 39) == 0) begin
        cmd_backlog.push_back(fragment(8'($urandom_range(1, ID_LIMIT - 2)),
                                       $urandom_range(0, PAY_BYTES)));
      end else begin
        cmd_backlog.push_back(command(CMD_VERIFY));
      end
    end
    settle();

    set_budget(8'd1);
    repeat (2) queue_session();
    settle();

    repeat (3) begin
      set_budget(8'($urandom_range(2, 254)));
      queue_session();
      settle();
    end

    set_budget(COUNT_MAX);
    queue_session();
    settle();

    if (response_backlog.size() != 0) begin
      $error("%0d responses never arrived", response_backlog.size());
    end
    if (fails == 0 && response_backlog.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
